### rtl/swrp_pkg.sv
// Shared types and constants for the sliding window refill planner.
// Used by the front, queue, back and top-level modules; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package swrp_pkg;

  localparam int POS_W     = 32;
  localparam int FRAC_BITS = 8;
  localparam int COORD_W   = 20;
  localparam int CNT_W     = 5;
  // Row counts reach 2D+1; six bits cover every supported load distance.
  localparam int ROW_W     = 6;

  typedef logic signed [COORD_W-1:0] coord_t;

  // One classified position change, handed from front to back.
  typedef struct packed {
    coord_t             new_x;
    coord_t             new_z;
    coord_t             old_x;
    coord_t             old_z;
    logic               sx_neg;
    logic               sz_neg;
    logic [ROW_W-1:0]   full_rows;
    logic [ROW_W-1:0]   left_rows;
    logic [CNT_W-1:0]   h_count;
  } cmd_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_FULL,
    BK_LEFT
  } bk_state_e;

endpackage

`default_nettype wire

### rtl/swrp_front.sv
// Front end: takes positions, converts them to tile coordinates and
// classifies the move against the kept tile. Depends on swrp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module swrp_front #(
  parameter int LOAD_DISTANCE = 10,
  parameter int TILE_SHIFT    = 4
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [swrp_pkg::POS_W-1:0]  pos_x_i,
  input  wire logic [swrp_pkg::POS_W-1:0]  pos_z_i,
  input  wire logic                        full_i,
  output logic                             push_o,
  output swrp_pkg::cmd_t                   cmd_o
);
  import swrp_pkg::*;

  localparam int SHIFT = FRAC_BITS + TILE_SHIFT;
  localparam logic signed [COORD_W:0] RANGE_W = (COORD_W+1)'(2*LOAD_DISTANCE+1);
  localparam logic signed [COORD_W:0] RANGE_N = -RANGE_W;
  localparam logic [ROW_W-1:0]        RANGE_R = ROW_W'(2*LOAD_DISTANCE+1);

  coord_t prev_x_q, prev_x_d;
  coord_t prev_z_q, prev_z_d;

  logic signed [POS_W-1:0]   shx, shz;
  coord_t                    nx, nz;
  logic signed [COORD_W:0]   mx, mz;
  logic                      lt_x, lt_z;
  logic [ROW_W-1:0]          amx_lo, amz_lo, full_rows;
  logic                      accept, moved_x, moved;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    shx = $signed(pos_x_i) >>> SHIFT;
    shz = $signed(pos_z_i) >>> SHIFT;
    nx  = shx[COORD_W-1:0];
    nz  = shz[COORD_W-1:0];
    mx  = {nx[COORD_W-1], nx} - {prev_x_q[COORD_W-1], prev_x_q};
    mz  = {nz[COORD_W-1], nz} - {prev_z_q[COORD_W-1], prev_z_q};
    // |m| < range without a full-width absolute value
    lt_x = mx[COORD_W] ? (mx > RANGE_N) : (mx < RANGE_W);
    lt_z = mz[COORD_W] ? (mz > RANGE_N) : (mz < RANGE_W);
    amx_lo = mx[COORD_W] ? ROW_W'(-mx[ROW_W-1:0]) : mx[ROW_W-1:0];
    amz_lo = mz[COORD_W] ? ROW_W'(-mz[ROW_W-1:0]) : mz[ROW_W-1:0];
    full_rows = lt_z ? amz_lo : RANGE_R;
    moved_x = (mx != '0);
    moved   = moved_x || (mz != '0);

    cmd_o.new_x     = nx;
    cmd_o.new_z     = nz;
    cmd_o.old_x     = prev_x_q;
    cmd_o.old_z     = prev_z_q;
    cmd_o.sx_neg    = mx[COORD_W];
    cmd_o.sz_neg    = mz[COORD_W];
    cmd_o.full_rows = full_rows;
    cmd_o.left_rows = moved_x ? ROW_W'(RANGE_R - full_rows) : '0;
    cmd_o.h_count   = lt_x ? amx_lo[CNT_W-1:0] : RANGE_R[CNT_W-1:0];

    push_o   = accept && moved;
    prev_x_d = accept ? nx : prev_x_q;
    prev_z_d = accept ? nz : prev_z_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_x_q <= '0;
      prev_z_q <= '0;
    end else begin
      prev_x_q <= prev_x_d;
      prev_z_q <= prev_z_d;
    end
  end

endmodule

`default_nettype wire

### rtl/swrp_queue.sv
// Two-entry command queue between front and back.
// Depends on swrp_pkg for the command type.
`timescale 1ns / 1ps
`default_nettype none

module swrp_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire swrp_pkg::cmd_t  cmd_i,
  output logic                 full_o,
  input  wire logic            pop_i,
  output swrp_pkg::cmd_t       cmd_o,
  output logic                 empty_o
);
  import swrp_pkg::*;

  cmd_t       mem_q [2];
  logic       wptr_q, wptr_d;
  logic       rptr_q, rptr_d;
  logic [1:0] fill_q, fill_d;
  logic       do_push, do_pop;

  assign full_o  = (fill_q == 2'd2);
  assign empty_o = (fill_q == 2'd0);
  assign cmd_o   = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wptr_d = do_push ? !wptr_q : wptr_q;
    rptr_d = do_pop ? !rptr_q : rptr_q;
    fill_d = fill_q + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      fill_q <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      fill_q <= fill_d;
    end
  end

endmodule

`default_nettype wire

### rtl/swrp_back.sv
// Back end: walks full-row and leftover strips of one command into an output
// register, one strip per cycle unless output stalls. Depends on swrp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module swrp_back #(
  parameter int LOAD_DISTANCE = 10
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire swrp_pkg::cmd_t              cmd_i,
  input  wire logic                        empty_i,
  output logic                             pop_o,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output swrp_pkg::coord_t                 load_x_o,
  output swrp_pkg::coord_t                 load_z_o,
  output swrp_pkg::coord_t                 unload_x_o,
  output swrp_pkg::coord_t                 unload_z_o,
  output logic [swrp_pkg::CNT_W-1:0]       count_o,
  output logic                             load_step_neg_o,
  output logic                             last_o
);
  import swrp_pkg::*;

  localparam coord_t         DIST    = COORD_W'(LOAD_DISTANCE);
  localparam logic [CNT_W-1:0] RANGE_C = CNT_W'(2*LOAD_DISTANCE+1);
  localparam coord_t         ONE     = COORD_W'(1);

  bk_state_e state_q, state_d;

  cmd_t             cur_q;
  logic [ROW_W-1:0] rows_q;
  coord_t           lx_q, lz_q, ux_q, uz_q;
  logic [CNT_W-1:0] cnt_q;
  logic             neg_q;

  logic             ov_q;
  coord_t           o_lx_q, o_lz_q, o_ux_q, o_uz_q;
  logic [CNT_W-1:0] o_cnt_q;
  logic             o_neg_q, o_last_q;

  logic   emit, row_end, to_left, pop;
  cmd_t   src;
  coord_t dx, dz, zstep;

  // control outputs of the sequencer
  always_comb begin
    pop     = (state_q == BK_IDLE) && !empty_i;
    emit    = (state_q != BK_IDLE) && (!ov_q || out_ready_i);
    row_end = (rows_q == ROW_W'(1));
    to_left = emit && (state_q == BK_FULL) && row_end && (cur_q.left_rows != '0);
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: begin
        if (pop) begin
          state_d = (cmd_i.full_rows != '0) ? BK_FULL : BK_LEFT;
        end
      end
      BK_FULL: begin
        if (emit && row_end) begin
          state_d = (cur_q.left_rows != '0) ? BK_LEFT : BK_IDLE;
        end
      end
      BK_LEFT: begin
        if (emit && row_end) begin
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_comb begin
    src   = (state_q == BK_IDLE) ? cmd_i : cur_q;
    dx    = src.sx_neg ? -DIST : DIST;
    dz    = src.sz_neg ? -DIST : DIST;
    zstep = cur_q.sz_neg ? -ONE : ONE;
  end

  assign pop_o = pop;

  always_ff @(posedge clk_i) begin
    if (pop) begin
      cur_q <= cmd_i;
    end
    if ((pop && (cmd_i.full_rows == '0)) || to_left) begin
      // start the leftover rows
      rows_q <= src.left_rows;
      lx_q   <= src.new_x + dx;
      ux_q   <= src.old_x - dx;
      lz_q   <= src.new_z - dz;
      uz_q   <= src.old_z + dz;
      cnt_q  <= src.h_count;
      neg_q  <= !src.sx_neg;
    end else if (pop) begin
      rows_q <= cmd_i.full_rows;
      lx_q   <= cmd_i.new_x - DIST;
      ux_q   <= cmd_i.old_x + DIST;
      lz_q   <= cmd_i.new_z + dz;
      uz_q   <= cmd_i.old_z - dz;
      cnt_q  <= RANGE_C;
      neg_q  <= 1'b0;
    end else if (emit) begin
      rows_q <= rows_q - ROW_W'(1);
      if (state_q == BK_FULL) begin
        lz_q <= lz_q - zstep;
        uz_q <= uz_q + zstep;
      end else begin
        lz_q <= lz_q + zstep;
        uz_q <= uz_q - zstep;
      end
    end
    if (emit) begin
      o_lx_q   <= lx_q;
      o_lz_q   <= lz_q;
      o_ux_q   <= ux_q;
      o_uz_q   <= uz_q;
      o_cnt_q  <= cnt_q;
      o_neg_q  <= neg_q;
      o_last_q <= row_end && ((state_q == BK_LEFT) || (cur_q.left_rows == '0));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (emit) begin
        ov_q <= 1'b1;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  assign out_valid_o     = ov_q;
  assign load_x_o        = o_lx_q;
  assign load_z_o        = o_lz_q;
  assign unload_x_o      = o_ux_q;
  assign unload_z_o      = o_uz_q;
  assign count_o         = o_cnt_q;
  assign load_step_neg_o = o_neg_q;
  assign last_o          = o_last_q;

endmodule

`default_nettype wire

### rtl/sliding_window_refill_planner_unit.sv
// Top level of the sliding window refill planner.
// Instantiates swrp_front, swrp_queue and swrp_back; depends on swrp_pkg.
//
// Each accepted position (x, z, fixed point with 8 fraction bits) is floored
// to a tile by an arithmetic shift of 8+TILE_SHIFT bits. When the tile
// differs from the one kept, the block emits one strip descriptor per cycle
// unless the output stalls: first min(|dz|, 2D+1) full rows, then, if x moved,
// the remaining rows as leftover strips; tlast marks the final strip of a
// position, and a position that stays on its tile yields nothing. The front
// end classifies a position combinationally and pushes it into the two-entry
// queue; the back end takes a command from the queue while idle and then
// walks its strips. The front end keeps taking positions while the queue has
// room.
`timescale 1ns / 1ps
`default_nettype none

module sliding_window_refill_planner_unit #(
  parameter int LOAD_DISTANCE = 10,
  parameter int TILE_SHIFT    = 4
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [63:0] s_axis_tdata,   // pos_x[31:0], pos_z[63:32]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [87:0]      m_axis_tdata,   // load_x[19:0], load_z[39:20],
                                           // unload_x[59:40], unload_z[79:60],
                                           // count[84:80], load_step_neg[85]
  output logic             m_axis_tlast
);
  import swrp_pkg::*;

  cmd_t             f_cmd, q_cmd;
  logic             push, q_full, q_empty, pop;
  coord_t           load_x, load_z, unload_x, unload_z;
  logic [CNT_W-1:0] count;
  logic             load_step_neg;

  swrp_front #(
    .LOAD_DISTANCE (LOAD_DISTANCE),
    .TILE_SHIFT    (TILE_SHIFT)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .pos_x_i    (s_axis_tdata[31:0]),
    .pos_z_i    (s_axis_tdata[63:32]),
    .full_i     (q_full),
    .push_o     (push),
    .cmd_o      (f_cmd)
  );

  swrp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (f_cmd),
    .full_o  (q_full),
    .pop_i   (pop),
    .cmd_o   (q_cmd),
    .empty_o (q_empty)
  );

  swrp_back #(
    .LOAD_DISTANCE (LOAD_DISTANCE)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (q_cmd),
    .empty_i         (q_empty),
    .pop_o           (pop),
    .out_valid_o     (m_axis_tvalid),
    .out_ready_i     (m_axis_tready),
    .load_x_o        (load_x),
    .load_z_o        (load_z),
    .unload_x_o      (unload_x),
    .unload_z_o      (unload_z),
    .count_o         (count),
    .load_step_neg_o (load_step_neg),
    .last_o          (m_axis_tlast)
  );

  assign m_axis_tdata = {2'b00, load_step_neg, count, unload_z, unload_x, load_z, load_x};

endmodule

`default_nettype wire
